// ===== rtl/hri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hri_pkg
// Shared constants and types for the Halton radical inverse block.
// ----------------------------------------------------------------------------
package hri_pkg;

  localparam int INDEX_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int BASE_W            = 5;
  localparam int MIN_BASE          = 2;

  // One doubling step travelling between neighbouring cells.
  typedef struct packed {
    logic v;
    logic c;
  } hri_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN
  } hri_state_t;

endpackage

// ===== rtl/hri_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hri_cell
// One base-b digit of the conversion row, doubled with carry in each step.
// ----------------------------------------------------------------------------
module hri_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic [hri_pkg::BASE_W-1:0] base,
  input  hri_pkg::hri_link_t        up_in,
  output hri_pkg::hri_link_t        up_out,
  input  hri_pkg::hri_link_t        dn_in,
  output hri_pkg::hri_link_t        dn_out
);
  import hri_pkg::*;

  logic [BASE_W-1:0] digit_r, digit_nxt;
  logic [BASE_W:0]   dbl;
  logic [BASE_W:0]   red;
  logic              act;
  logic              cin;
  logic              carry;
  hri_link_t         up_out_r, dn_out_r;

  // A step arrives from at most one side at a time.
  always_comb begin
    act   = up_in.v | dn_in.v;
    cin   = up_in.v ? up_in.c : dn_in.c;
    dbl   = {digit_r, 1'b0} + (BASE_W + 1)'(cin);
    carry = 1'b0;
    red   = dbl;
    if (dbl >= {1'b0, base}) begin
      carry = 1'b1;
      red   = dbl - {1'b0, base};
    end
    if (clr) begin
      digit_nxt = '0;
    end else if (act) begin
      digit_nxt = red[BASE_W-1:0];
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_out_r <= '0;
      dn_out_r <= '0;
    end else begin
      up_out_r.v <= up_in.v;
      up_out_r.c <= up_in.v & carry;
      dn_out_r.v <= dn_in.v;
      dn_out_r.c <= dn_in.v & carry;
    end
  end

  assign up_out = up_out_r;
  assign dn_out = dn_out_r;

endmodule

// ===== rtl/halton_radical_inverse_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halton_radical_inverse_top
// Halton radical inverse of an index in a given base, as a signed fixed-point
// fraction, optionally centred by subtracting one half.
// ----------------------------------------------------------------------------
// Timing: out_strobe rises in the same cycle that busy falls.
// A new item is taken only once busy has fallen, after the doubling steps
// of both phases have travelled through the row of INDEX_BITS digit cells.
// Reset: synchronous, active low; the block comes out idle with no result pending.
// The receiver cannot stall: out_strobe marks each result for one cycle only.
module halton_radical_inverse_top #(
  parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
  parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [hri_pkg::BASE_W-1:0] in_base,
  input  logic [INDEX_BITS-1:0]      in_index,
  output logic                       out_strobe,
  output logic signed [FRACTION_BITS:0] out_value
);
  import hri_pkg::*;

  // The row needs one cell per binary digit, since base two has the most digits.
  localparam int NCELL   = INDEX_BITS;
  localparam int UP_LAST = INDEX_BITS + NCELL - 1;
  localparam int DN_LAST = FRACTION_BITS + NCELL - 1;
  localparam int CNT_MAX = (UP_LAST > DN_LAST) ? UP_LAST : DN_LAST;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  // How it works. The row of cells holds the index as base-b digits, cell 0
  // being the least significant. In the up phase the index bits are fed into
  // cell 0 most significant first; each step doubles the digit string and
  // adds the bit, with carries travelling upwards one cell per cycle, so
  // successive steps follow one another in a skewed wave.
  //
  // Read the other way round the same digits are the base-b fraction of the
  // radical inverse, cell 0 holding its first digit. In the down phase the
  // fraction is doubled FRACTION_BITS times, carries travelling from the top
  // cell towards cell 0, and the carry out of cell 0 is the next binary digit
  // of the result. Doubling is exact, so the bits are the truncated value.

  hri_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic                  mode_r, mode_nxt;
  logic [FRACTION_BITS-1:0] q_r, q_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic signed [FRACTION_BITS:0] out_value_r, out_value_nxt;
  logic                  clr;
  hri_link_t             up_inj, dn_inj;
  hri_link_t             up_l [0:NCELL];
  hri_link_t             dn_l [0:NCELL];

  assign up_l[0]     = up_inj;
  assign dn_l[NCELL] = dn_inj;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hri_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clr    (clr),
      .base   (base_r),
      .up_in  (up_l[k]),
      .up_out (up_l[k+1]),
      .dn_in  (dn_l[k+1]),
      .dn_out (dn_l[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    mode_nxt       = mode_r;
    up_inj         = '0;
    dn_inj         = '0;
    clr            = 1'b0;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    // Result bits leave cell 0 most significant first.
    q_nxt = dn_l[0].v ? {q_r[FRACTION_BITS-2:0], dn_l[0].c} : q_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          clr       = 1'b1;
          state_nxt = ST_UP;
          cnt_nxt   = '0;
          idx_nxt   = in_index;
          mode_nxt  = in_mode;
          // A base below two is taken as two.
          base_nxt  = (in_base < BASE_W'(MIN_BASE)) ? BASE_W'(MIN_BASE) : in_base;
        end
      end
      ST_UP: begin
        if (cnt_r < CNT_W'(INDEX_BITS)) begin
          up_inj.v = 1'b1;
          up_inj.c = idx_r[INDEX_BITS-1];
          idx_nxt  = {idx_r[INDEX_BITS-2:0], 1'b0};
        end
        // The last index step leaving the top cell ends the up phase.
        if (up_l[NCELL].v && (cnt_r == CNT_W'(UP_LAST))) begin
          state_nxt = ST_DOWN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DOWN: begin
        if (cnt_r < CNT_W'(FRACTION_BITS)) begin
          dn_inj.v = 1'b1;
        end
        if (cnt_r == CNT_W'(DN_LAST)) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_value_nxt  = $signed({1'b0, q_nxt}
                           - ((FRACTION_BITS + 1)'(mode_r) << (FRACTION_BITS - 1)));
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    base_r      <= base_nxt;
    mode_r      <= mode_nxt;
    q_r         <= q_nxt;
    out_value_r <= out_value_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;

endmodule

// ===== verif/halton_radical_inverse_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halton_radical_inverse_top_tb
// Self-checking bench for the Halton radical inverse block. A directed set of
// corner items is followed by several hundred random items with random gaps;
// every result is compared against an in-bench model of the mirrored-digit
// fraction, truncated to the fixed-point output width.
// ----------------------------------------------------------------------------

// Holds the values the block should produce, oldest first, and keeps the tally.
class hri_scoreboard;

  localparam int IB = hri_pkg::INDEX_BITS_DEF;
  localparam int FB = hri_pkg::FRACTION_BITS_DEF;

  typedef struct packed {
    logic                        mode;
    logic [hri_pkg::BASE_W-1:0]  base;
    logic [IB-1:0]               index;
    logic [FB:0]                 value;
  } pending_t;

  pending_t pending_values[$];
  int       errors;
  int       checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  // Mirror the base digits of the index about the radix point, then scale
  // the exact fraction by 2^FB and truncate. Centred mode takes away one half.
  function logic [FB:0] radical_inverse(logic mode, logic [hri_pkg::BASE_W-1:0] base,
                                        logic [IB-1:0] index);
    logic [63:0] radix;
    logic [63:0] rest;
    logic [63:0] mirrored;
    logic [63:0] denom;
    logic [63:0] frac;
    radix    = (base < hri_pkg::MIN_BASE) ? 64'(hri_pkg::MIN_BASE) : 64'(base);
    rest     = 64'(index);
    mirrored = 0;
    denom    = 1;
    while (rest != 0) begin
      mirrored = mirrored * radix + (rest % radix);
      denom    = denom * radix;
      rest     = rest / radix;
    end
    frac = (mirrored << FB) / denom;
    if (mode) begin
      frac = frac - (64'd1 << (FB - 1));
    end
    return frac[FB:0];
  endfunction

  function void note_item(logic mode, logic [hri_pkg::BASE_W-1:0] base, logic [IB-1:0] index);
    pending_t p;
    p.mode  = mode;
    p.base  = base;
    p.index = index;
    p.value = radical_inverse(mode, base, index);
    pending_values.push_back(p);
  endfunction

  function void check_result(logic [FB:0] value);
    pending_t p;
    if (pending_values.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: result %h arrived with no item outstanding", value);
      end
    end else begin
      p = pending_values.pop_front();
      checked++;
      if (value !== p.value) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: mode %0d base %0d index %0d: expected %h, got %h",
                   p.mode, p.base, p.index, p.value, value);
        end
      end
    end
  endfunction

  function int outstanding();
    return pending_values.size();
  endfunction

endclass

module halton_radical_inverse_top_tb;

  localparam int IB        = hri_pkg::INDEX_BITS_DEF;
  localparam int FB        = hri_pkg::FRACTION_BITS_DEF;
  localparam int BW        = hri_pkg::BASE_W;
  // Nominal result delay of the block, used to size idle gaps and the drain.
  localparam int LATENCY   = 3 * IB + FB;
  localparam int N_RANDOM  = 600;
  // Worst case per item is the block's own time plus the longest idle gap;
  // the limit is several times the whole of that.
  localparam int MAX_CYCLES = 600000;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          in_mode;
  logic [BW-1:0] in_base;
  logic [IB-1:0] in_index;
  logic          out_strobe;
  logic signed [FB:0] out_value;

  hri_scoreboard sb;
  int            cycle_count;
  int            n_items;
  int            n_centred;
  int            n_low_base;
  bit            burst;

  halton_radical_inverse_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_base    (in_base),
    .in_index   (in_index),
    .out_strobe (out_strobe),
    .out_value  (out_value)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // Watch both channels at each rising edge. Everything read here holds the
  // value it had during the cycle that the edge closes, since all drivers use
  // nonblocking assignments. An item is taken when start is high and busy low;
  // a result counts when the strobe was high.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_item(in_mode, in_base, in_index);
      end
      if (out_strobe) begin
        sb.check_result(out_value);
      end
    end
  end

  // A generous watchdog, so that a block that hangs cannot stall the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it. The task is called
  // at a rising edge and returns at the edge that accepted the item, with
  // start still high, so a following item can go straight out without start
  // dropping in between.
  task automatic issue(input logic mode, input logic [BW-1:0] base, input logic [IB-1:0] index);
    start    <= 1'b1;
    in_mode  <= mode;
    in_base  <= base;
    in_index <= index;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    n_items++;
    if (mode) begin
      n_centred++;
    end
    if (base < hri_pkg::MIN_BASE) begin
      n_low_base++;
    end
  endtask

  // Idle gap after an item: mostly none or short, now and then a long one
  // that lets the block run dry. During a burst there are no gaps at all.
  task automatic idle_gap();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (burst || r < 50) begin
      len = 0;
    end else if (r < 85) begin
      len = $urandom_range(1, 3);
    end else if (r < 97) begin
      len = $urandom_range(4, LATENCY);
    end else begin
      len = $urandom_range(LATENCY + 1, 150);
    end
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Random item. Bases are mostly in the meaningful range, with the odd
  // zero or one to exercise the saturation to base two. Indices are mostly
  // uniform, with extra weight on small values, values near the top and zero.
  task automatic random_item();
    logic          mode;
    logic [BW-1:0] base;
    logic [IB-1:0] index;
    int            r;
    mode = 1'($urandom_range(0, 1));
    r    = $urandom_range(0, 99);
    if (r < 6) begin
      base = BW'($urandom_range(0, 1));
    end else if (r < 40) begin
      base = BW'($urandom_range(2, 3));
    end else begin
      base = BW'($urandom_range(2, 31));
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      index = IB'($urandom);
    end else if (r < 80) begin
      index = IB'($urandom_range(0, 255));
    end else if (r < 95) begin
      index = {IB{1'b1}} - IB'($urandom_range(0, 255));
    end else begin
      index = '0;
    end
    issue(mode, base, index);
    idle_gap();
  endtask

  initial begin
    sb          = new();
    cycle_count = 0;
    n_items     = 0;
    n_centred   = 0;
    n_low_base  = 0;
    burst       = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = 1'b0;
    in_base     = '0;
    in_index    = '0;

    // Synchronous reset, held low and then released at an edge.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: index zero in both modes, base zero and one (taken as
    // base two), the smallest and largest bases with the largest index, and a
    // few values whose fraction lands exactly on one half or just below one.
    issue(1'b0, 5'd2,  16'd0);     idle_gap();
    issue(1'b1, 5'd2,  16'd0);     idle_gap();
    issue(1'b0, 5'd0,  16'd5);     idle_gap();
    issue(1'b1, 5'd1,  16'd5);     idle_gap();
    issue(1'b1, 5'd0,  16'd0);     idle_gap();
    issue(1'b0, 5'd2,  16'd1);     idle_gap();
    issue(1'b1, 5'd2,  16'd1);     idle_gap();
    issue(1'b0, 5'd2,  16'hFFFF);  idle_gap();
    issue(1'b1, 5'd2,  16'hFFFF);  idle_gap();
    issue(1'b0, 5'd2,  16'h8000);  idle_gap();
    issue(1'b0, 5'd31, 16'hFFFF);  idle_gap();
    issue(1'b1, 5'd31, 16'hFFFF);  idle_gap();
    issue(1'b0, 5'd31, 16'd30);    idle_gap();
    issue(1'b1, 5'd31, 16'd1);     idle_gap();
    issue(1'b1, 5'd31, 16'd0);     idle_gap();
    issue(1'b0, 5'd3,  16'd1);     idle_gap();
    issue(1'b1, 5'd3,  16'd59048); idle_gap();
    issue(1'b0, 5'd17, 16'hFFFF);  idle_gap();
    issue(1'b0, 5'd5,  16'd0);     idle_gap();
    issue(1'b0, 5'd7,  16'd12345); idle_gap();
    issue(1'b1, 5'd16, 16'h5555);  idle_gap();
    issue(1'b0, 5'd30, 16'hAAAA);  idle_gap();

    // Random part. Every so often a burst of back-to-back items begins, so
    // that long stretches see no idling at all.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      random_item();
    end
    start <= 1'b0;

    // Drain: wait for every outstanding result, then run on for longer than the
    // block's result delay so that any stray extra strobe is still caught.
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d items (%0d centred, %0d with base below two); %0d results checked.",
             n_items, n_centred, n_low_base, sb.checked);
    $display("Mismatches and unexpected results: %0d", sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hri_pkg.sv
rtl/hri_cell.sv
rtl/halton_radical_inverse_top.sv
verif/halton_radical_inverse_top_tb.sv
